// ===== hw/rtl/ptq_pkg.sv =====
// ----------------------------------------------------------------------------
// ptq_pkg
// Shared types and constants of the priority task queue: field widths,
// status codes, stored entry layout and controller states.
// ----------------------------------------------------------------------------
package ptq_pkg;

  localparam int PRI_W    = 8;
  localparam int TAG_W    = 16;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2,
    STATUS_FAIL  = 2'd3
  } status_t;

  typedef struct packed {
    logic [PRI_W-1:0] pri;
    logic [TAG_W-1:0] tag;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SERVE,
    ST_SCAN
  } state_t;

endpackage

// ===== hw/rtl/ptq_mem.sv =====
// ----------------------------------------------------------------------------
// ptq_mem
// Entry store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ptq_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int W     = 24
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/priority_task_queue_core.sv =====
// ----------------------------------------------------------------------------
// priority_task_queue_core
// Bounded priority queue of tasks held in arrival order in one entry memory.
// Add appends an entry; serve returns the best entry (highest priority,
// earliest on a tie) and, if it is removed, keeps order and finds the best again.
//
//   channel | direction | transfer when         | payload
//   in_     | input     | in_valid & in_ready   | kind, priority, tag, handled_ok
//   out_    | output    | out_valid & out_ready | status, served prio/tag, count
//   cfg_    | input     | cfg_valid & cfg_ready | keep_on_failure
//
// Add writes the entry from idle; serve reads the best entry, then returns it.
// A failed entry stays when keep_on_failure is set. Removal with N >= 2 entries
// held makes one memory pass: later entries move down a slot, all are rescanned.
// Reset clears count, best index, keep flag and output valid; the memory needs no clear.
// A new item is taken only when idle and the output register is free.
// ----------------------------------------------------------------------------
module priority_task_queue_core #(
  parameter int CAPACITY = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_kind,
  input  logic [ptq_pkg::PRI_W-1:0]  in_task_priority,
  input  logic [ptq_pkg::TAG_W-1:0]  in_task_tag,
  input  logic                       in_handled_ok,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [ptq_pkg::STATUS_W-1:0] out_status,
  output logic [ptq_pkg::PRI_W-1:0]  out_served_priority,
  output logic [ptq_pkg::TAG_W-1:0]  out_served_tag,
  output logic [ptq_pkg::COUNT_W-1:0] out_entry_count,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic                       cfg_keep_on_failure
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  ptq_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [AW-1:0]   best_r, best_nxt;
  logic [ptq_pkg::PRI_W-1:0] bestpri_r, bestpri_nxt;
  logic            keep_r;
  logic            handled_r, handled_nxt;
  logic [AW-1:0]   obest_r, obest_nxt;
  logic [AW-1:0]   last_r, last_nxt;
  logic [AW-1:0]   j_r, j_nxt;
  logic            issue_done_r, issue_done_nxt;
  logic            pv_r, pv_nxt;
  logic [AW-1:0]   pj_r, pj_nxt;
  logic            out_valid_r, out_valid_nxt;
  ptq_pkg::status_t out_status_r, out_status_nxt;
  logic [ptq_pkg::PRI_W-1:0] out_pri_r, out_pri_nxt;
  logic [ptq_pkg::TAG_W-1:0] out_tag_r, out_tag_nxt;
  logic [ptq_pkg::COUNT_W-1:0] out_cnt_r, out_cnt_nxt;

  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  ptq_pkg::entry_t mem_wdata;
  logic            mem_re;
  logic [AW-1:0]   mem_raddr;
  logic [ptq_pkg::ENTRY_W-1:0] mem_rdata_raw;
  ptq_pkg::entry_t mem_rdata;
  logic            out_free;
  logic [AW-1:0]   scan_idx;
  logic            remove;

  ptq_mem #(
    .DEPTH (CAPACITY),
    .AW    (AW),
    .W     (ptq_pkg::ENTRY_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata_raw)
  );

  assign mem_rdata = ptq_pkg::entry_t'(mem_rdata_raw);
  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ptq_pkg::ST_IDLE) && out_free;
  assign cfg_ready = 1'b1;
  assign scan_idx  = (pj_r < obest_r) ? pj_r : pj_r - 1'b1;
  assign remove    = handled_r || !keep_r;

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    best_nxt       = best_r;
    bestpri_nxt    = bestpri_r;
    handled_nxt    = handled_r;
    obest_nxt      = obest_r;
    last_nxt       = last_r;
    j_nxt          = j_r;
    issue_done_nxt = issue_done_r;
    pv_nxt         = 1'b0;
    pj_nxt         = pj_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_pri_nxt    = out_pri_r;
    out_tag_nxt    = out_tag_r;
    out_cnt_nxt    = out_cnt_r;
    mem_we         = 1'b0;
    mem_waddr      = '0;
    mem_wdata      = '0;
    mem_re         = 1'b0;
    mem_raddr      = '0;

    case (state_r)
      ptq_pkg::ST_IDLE: begin
        if (in_valid && in_ready) begin
          handled_nxt = in_handled_ok;
          out_pri_nxt = '0;
          out_tag_nxt = '0;
          out_cnt_nxt = ptq_pkg::COUNT_W'(count_r);
          if (!in_kind) begin
            out_valid_nxt = 1'b1;
            if (count_r == CW'(CAPACITY)) begin
              out_status_nxt = ptq_pkg::STATUS_FULL;
            end else begin
              out_status_nxt = ptq_pkg::STATUS_OK;
              mem_we         = 1'b1;
              mem_waddr      = count_r[AW-1:0];
              mem_wdata.pri  = in_task_priority;
              mem_wdata.tag  = in_task_tag;
              count_nxt      = count_r + 1'b1;
              out_cnt_nxt    = ptq_pkg::COUNT_W'(count_r + 1'b1);
              if (count_r == '0) begin
                best_nxt    = '0;
                bestpri_nxt = in_task_priority;
              end else if (in_task_priority > bestpri_r) begin
                best_nxt    = count_r[AW-1:0];
                bestpri_nxt = in_task_priority;
              end
            end
          end else if (count_r == '0) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = ptq_pkg::STATUS_EMPTY;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = best_r;
            state_nxt = ptq_pkg::ST_SERVE;
          end
        end
      end

      ptq_pkg::ST_SERVE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_pri_nxt    = mem_rdata.pri;
          out_tag_nxt    = mem_rdata.tag;
          out_status_nxt = handled_r ? ptq_pkg::STATUS_OK : ptq_pkg::STATUS_FAIL;
          out_cnt_nxt    = ptq_pkg::COUNT_W'(count_r);
          state_nxt      = ptq_pkg::ST_IDLE;
          if (remove) begin
            count_nxt   = count_r - 1'b1;
            out_cnt_nxt = ptq_pkg::COUNT_W'(count_r - 1'b1);
            if (count_r == CW'(1)) begin
              best_nxt = '0;
            end else begin
              obest_nxt      = best_r;
              last_nxt       = AW'(count_r - 1'b1);
              j_nxt          = '0;
              issue_done_nxt = 1'b0;
              state_nxt      = ptq_pkg::ST_SCAN;
            end
          end
        end
      end

      ptq_pkg::ST_SCAN: begin
        if (!issue_done_r) begin
          mem_re    = 1'b1;
          mem_raddr = j_r;
          j_nxt     = j_r + 1'b1;
          pv_nxt    = 1'b1;
          pj_nxt    = j_r;
          if (j_r == last_r) begin
            issue_done_nxt = 1'b1;
          end
        end
        if (pv_r) begin
          if (pj_r != obest_r) begin
            if (pj_r > obest_r) begin
              mem_we    = 1'b1;
              mem_waddr = pj_r - 1'b1;
              mem_wdata = mem_rdata;
            end
            if (scan_idx == '0 || mem_rdata.pri > bestpri_r) begin
              best_nxt    = scan_idx;
              bestpri_nxt = mem_rdata.pri;
            end
          end
          if (pj_r == last_r) begin
            state_nxt = ptq_pkg::ST_IDLE;
          end
        end
      end

      default: begin
        state_nxt = ptq_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ptq_pkg::ST_IDLE;
      count_r      <= '0;
      best_r       <= '0;
      keep_r       <= 1'b0;
      issue_done_r <= 1'b1;
      pv_r         <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      best_r       <= best_nxt;
      issue_done_r <= issue_done_nxt;
      pv_r         <= pv_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        keep_r <= cfg_keep_on_failure;
      end
    end
  end

  always_ff @(posedge clk) begin
    bestpri_r    <= bestpri_nxt;
    handled_r    <= handled_nxt;
    obest_r      <= obest_nxt;
    last_r       <= last_nxt;
    j_r          <= j_nxt;
    pj_r         <= pj_nxt;
    out_status_r <= out_status_nxt;
    out_pri_r    <= out_pri_nxt;
    out_tag_r    <= out_tag_nxt;
    out_cnt_r    <= out_cnt_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_served_priority = out_pri_r;
  assign out_served_tag      = out_tag_r;
  assign out_entry_count     = out_cnt_r;

endmodule
